/* rtl/sbfe_pkg.sv */
// ----------------------------------------------------------------------------
// sbfe_pkg
// Shared constants and types for the serial-bus frame encoder.
// ----------------------------------------------------------------------------
package sbfe_pkg;

    // Frame geometry
    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_BITS    = 11;
    localparam int CNT_W        = $clog2(NUM_CHANNELS);
    localparam int LEFT_W       = 7;                    // leftover bits below one byte
    localparam int HELD_W       = 3;
    localparam int ACC_W        = CHAN_BITS + LEFT_W;   // packing window
    localparam int TOT_W        = $clog2(ACC_W + 1);

    // Bytes carried by one command
    localparam int MAX_OUT = 4;
    localparam int SLOT_W  = $clog2(MAX_OUT);
    localparam int NUM_W   = $clog2(MAX_OUT + 1);

    localparam logic [7:0] FLAG_BYTE     = 8'h00;
    localparam logic [7:0] START_RST_VAL = 8'hF0;
    localparam logic [7:0] END_RST_VAL   = 8'h00;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int ADDR_W = 3;
    localparam logic REG_START_IDX = 1'b0;
    localparam logic REG_END_IDX   = 1'b1;

    // One command: the bytes caused by one channel transfer
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [NUM_W-1:0]        count;
        logic                    is_last;
    } t_cmd;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* rtl/sbus_frame_encoder.sv */
// ----------------------------------------------------------------------------
// sbus_frame_encoder
// The first byte of a channel transfer passes the command queue and then the
// registered output stage. The back sends one byte per cycle while the output
// is not stalled; a frame of 16 channels gives 25 bytes, so output sets the pace.
// The front takes a channel each cycle while the two-entry queue has room.
// Reset (synchronous, active low) clears the frame position and the queue
// and loads start byte 0xF0 and end byte 0x00.
// ----------------------------------------------------------------------------
module sbus_frame_encoder
    import sbfe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Channel input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CHAN_BITS-1:0] i_channel_value,
    // Byte output
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_out_byte,
    output logic                 o_frame_end,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [7:0] r_start_byte;
    logic [7:0] r_end_byte;
    logic       cfg_wr;
    logic       push;
    logic       pop;
    t_cmd       cmd;
    t_cmd       head;
    t_q_status  status;

    // Register writes complete in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_RST_VAL;
            r_end_byte   <= END_RST_VAL;
        end else if (cfg_wr) begin
            case (paddr[ADDR_W-1])
                REG_START_IDX: r_start_byte <= pwdata[7:0];
                REG_END_IDX:   r_end_byte   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (paddr[ADDR_W-1])
            REG_START_IDX: prdata = {24'b0, r_start_byte};
            REG_END_IDX:   prdata = {24'b0, r_end_byte};
            default:       prdata = '0;
        endcase
    end

    sbfe_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_channel_value (i_channel_value),
        .i_start_byte    (r_start_byte),
        .i_end_byte      (r_end_byte),
        .i_status        (status),
        .o_push          (push),
        .o_cmd           (cmd)
    );

    sbfe_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (status)
    );

    sbfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_status    (status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end)
    );

endmodule

/* rtl/sbfe_front.sv */
// ----------------------------------------------------------------------------
// sbfe_front
// Accepts channel values, packs their bits and builds one byte command each.
// ----------------------------------------------------------------------------
module sbfe_front
    import sbfe_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [CHAN_BITS-1:0] i_channel_value,
    input  logic [7:0]           i_start_byte,
    input  logic [7:0]           i_end_byte,
    input  t_q_status            i_status,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic [LEFT_W-1:0] r_left, n_left;
    logic [HELD_W-1:0] r_held, n_held;
    logic [CNT_W-1:0]  r_chan, n_chan;
    logic              accept;

    // A transfer is taken whenever the queue has room.
    assign o_in_stall = i_status.full;
    assign accept     = i_in_valid && !i_status.full;
    assign o_push     = accept;

    // Pack the new value above the leftover bits and list the bytes it completes.
    always_comb begin
        logic [ACC_W-1:0]  win;
        logic [TOT_W-1:0]  total;
        logic [LEFT_W-1:0] rem;
        logic              two;
        logic              last;
        logic [NUM_W-1:0]  k;

        win   = ACC_W'(r_left) | (ACC_W'(i_channel_value) << r_held);
        total = TOT_W'(r_held) + TOT_W'(CHAN_BITS);
        two   = (total >= TOT_W'(16));
        rem   = two ? LEFT_W'(win[ACC_W-1:16]) : win[14:8];
        last  = (r_chan == CNT_W'(NUM_CHANNELS - 1));

        o_cmd   = '0;
        k       = '0;
        n_left  = rem;
        n_held  = total[HELD_W-1:0];
        n_chan  = r_chan + CNT_W'(1);

        if (r_chan == '0) begin
            o_cmd.bytes[k[SLOT_W-1:0]] = i_start_byte;
            k = k + NUM_W'(1);
        end
        o_cmd.bytes[k[SLOT_W-1:0]] = win[7:0];
        k = k + NUM_W'(1);
        if (two) begin
            o_cmd.bytes[k[SLOT_W-1:0]] = win[15:8];
            k = k + NUM_W'(1);
        end

        // Frame tail: padded leftover byte, flag byte if room, then end byte.
        if (last) begin
            if (n_held != '0 && k < NUM_W'(MAX_OUT)) begin
                o_cmd.bytes[k[SLOT_W-1:0]] = {1'b0, rem};
                k = k + NUM_W'(1);
            end
            if (k <= NUM_W'(MAX_OUT - 2)) begin
                o_cmd.bytes[k[SLOT_W-1:0]] = FLAG_BYTE;
                k = k + NUM_W'(1);
            end
            if (k < NUM_W'(MAX_OUT)) begin
                o_cmd.bytes[k[SLOT_W-1:0]] = i_end_byte;
                k = k + NUM_W'(1);
            end
            o_cmd.is_last = 1'b1;
            n_left = '0;
            n_held = '0;
            n_chan = '0;
        end
        o_cmd.count = k;
    end

    // Packing state advances on each accepted transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_held <= '0;
            r_chan <= '0;
        end else if (accept) begin
            r_left <= n_left;
            r_held <= n_held;
            r_chan <= n_chan;
        end
    end

endmodule

/* rtl/sbfe_queue.sv */
// ----------------------------------------------------------------------------
// sbfe_queue
// Short command queue that decouples the packing front from the byte back.
// ----------------------------------------------------------------------------
module sbfe_queue
    import sbfe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_head,
    output t_q_status o_status
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head          = r_mem[r_rd_ptr];
    assign o_status.full   = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty  = (r_count == '0);

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("push into full queue");
`endif

endmodule

/* rtl/sbfe_back.sv */
// ----------------------------------------------------------------------------
// sbfe_back
// Walks the head command byte by byte into a registered output stage.
// ----------------------------------------------------------------------------
module sbfe_back
    import sbfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  t_q_status  i_status,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end
);

    logic              r_ovalid, n_ovalid;
    logic [7:0]        r_obyte, n_obyte;
    logic              r_oend, n_oend;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              out_free;
    logic              fire;
    logic              at_last;

    assign out_free = !r_ovalid || !i_out_stall;
    assign fire     = out_free && !i_status.empty;
    assign at_last  = (r_idx == SLOT_W'(i_head.count - NUM_W'(1)));
    assign o_pop    = fire && at_last;

    // Next output byte and position within the head command.
    always_comb begin
        n_ovalid = r_ovalid;
        n_obyte  = r_obyte;
        n_oend   = r_oend;
        n_idx    = r_idx;
        if (fire) begin
            n_ovalid = 1'b1;
            n_obyte  = i_head.bytes[r_idx];
            n_oend   = i_head.is_last && at_last;
            n_idx    = at_last ? '0 : r_idx + SLOT_W'(1);
        end else if (out_free) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_ovalid <= n_ovalid;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_obyte <= n_obyte;
        r_oend  <= n_oend;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_frame_end = r_oend;

`ifndef SYNTH
    a_idx_in_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_status.empty |-> (NUM_W'(r_idx) < i_head.count))
        else $error("byte index beyond head command");
`endif

endmodule

/* tb/tb_sbus_frame_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sbus_frame_encoder
// Self-checking bench for the serial-bus frame encoder. Channel values are
// streamed in with random bursts and gaps. A local frame packer predicts every
// output byte and its end marker, and each byte transfer on the output side is
// checked in order. The start and end byte registers are written and read back
// over the configuration port between phases, including in the middle of a
// frame.
// ----------------------------------------------------------------------------
module tb_sbus_frame_encoder;
    import sbfe_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 80;

    typedef struct {
        logic [7:0] data;
        logic       frame_end;
    } t_frame_byte;

    // DUT connections
    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_in_valid      = 1'b0;
    logic                 o_in_stall;
    logic [CHAN_BITS-1:0] i_channel_value = '0;
    logic                 o_out_valid;
    logic                 i_out_stall     = 1'b0;
    logic [7:0]           o_out_byte;
    logic                 o_frame_end;
    logic                 psel            = 1'b0;
    logic                 penable         = 1'b0;
    logic                 pwrite          = 1'b0;
    logic [ADDR_W-1:0]    paddr           = '0;
    logic [31:0]          pwdata          = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Predictor state and the bytes still owed by the block
    logic [7:0]        cfg_start  = START_RST_VAL;
    logic [7:0]        cfg_end    = END_RST_VAL;
    logic [ACC_W-1:0]  pack_acc   = '0;
    logic [4:0]        pack_held  = '0;
    logic [CNT_W-1:0]  chan_idx   = '0;
    t_frame_byte       frame_q[$];
    t_frame_byte       owed_byte;

    int fail_count  = 0;
    int cycle_count = 0;
    int hold_cycles = 0;
    int stall_mode  = 0;
    int stall_left  = 0;

    sbus_frame_encoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_channel_value (i_channel_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_frame_end     (o_frame_end),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Clock: 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Output stall: a long hold when requested, otherwise random stretches
    // of no stall, light stall and heavy stall.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (stall_left == 0) begin
            stall_mode  <= $urandom_range(0, 2);
            stall_left  <= $urandom_range(10, 60);
            i_out_stall <= 1'b0;
        end else begin
            stall_left <= stall_left - 1;
            case (stall_mode)
                0: begin
                    i_out_stall <= 1'b0;
                end
                1: begin
                    i_out_stall <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    i_out_stall <= ($urandom_range(0, 9) < 6);
                end
            endcase
        end
    end

    // Compare each byte transfer with the oldest owed byte.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frame_q.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual %h frame_end %b",
                         $time, o_out_byte, o_frame_end);
                fail_count++;
            end else begin
                owed_byte = frame_q.pop_front();
                if (o_out_byte !== owed_byte.data) begin
                    $display("%0t: out_byte mismatch: expected %h, actual %h",
                             $time, owed_byte.data, o_out_byte);
                    fail_count++;
                end
                if (o_frame_end !== owed_byte.frame_end) begin
                    $display("%0t: frame_end mismatch: expected %b, actual %b",
                             $time, owed_byte.frame_end, o_frame_end);
                    fail_count++;
                end
            end
        end
    end

    // Queue one owed byte, keeping to the per-channel byte limit.
    task automatic owe_byte(inout int n, input logic [7:0] data, input logic last);
        t_frame_byte b;
        if (n < MAX_OUT) begin
            b.data      = data;
            b.frame_end = last;
            frame_q.push_back(b);
            n++;
        end
    endtask

    // Pack one channel into the frame and queue the bytes it releases.
    task automatic pack_channel(input logic [CHAN_BITS-1:0] value);
        int         n;
        logic       last_chan;
        logic [4:0] held;
        n         = 0;
        last_chan = (chan_idx >= CNT_W'(NUM_CHANNELS - 1));
        if (chan_idx == '0)
            owe_byte(n, cfg_start, 1'b0);
        held = pack_held;
        if (held > 5'd7)
            held = 5'd7;
        pack_acc = pack_acc | (ACC_W'(value) << held);
        held = held + 5'(CHAN_BITS);
        while (held >= 5'd8) begin
            owe_byte(n, pack_acc[7:0], 1'b0);
            pack_acc = pack_acc >> 8;
            held     = held - 5'd8;
        end
        if (last_chan) begin
            // Leftover bits go out zero-padded, then the flag and end bytes.
            if (held > 5'd0)
                owe_byte(n, pack_acc[7:0], 1'b0);
            if (n <= MAX_OUT - 2)
                owe_byte(n, FLAG_BYTE, 1'b0);
            owe_byte(n, cfg_end, 1'b1);
            pack_acc  = '0;
            pack_held = '0;
            chan_idx  = '0;
        end else begin
            pack_held = held;
            chan_idx  = chan_idx + 1'b1;
        end
    endtask

    // Offer one channel and hold it until the transfer completes.
    task automatic send_channel(input logic [CHAN_BITS-1:0] value);
        i_in_valid      <= 1'b1;
        i_channel_value <= value;
        do
            @(posedge i_clk);
        while (o_in_stall);
        pack_channel(value);
    endtask

    // With no gap asked for, the input stays offered.
    task automatic idle_input(input int cycles);
        if (cycles > 0) begin
            i_in_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every owed byte has come out.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (frame_q.size() != 0);
    endtask

    // Read a register and compare it; the port then goes idle.
    task automatic read_reg(input logic idx, input logic [7:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= '0;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        if (prdata !== 32'(want)) begin
            $display("%0t: register %0d read: expected %h, actual %h",
                     $time, idx, 32'(want), prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write a register, mirror it in the predictor and read it back.
    task automatic write_reg(input logic idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        if (idx == REG_START_IDX)
            cfg_start = value;
        else
            cfg_end = value;
        read_reg(idx, value);
    endtask

    function automatic logic [CHAN_BITS-1:0] rand_channel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return CHAN_BITS'($urandom_range(0, 2047));
        endcase
    endfunction

    // Registers come out of reset with their documented values.
    task automatic test_register_reset();
        read_reg(REG_START_IDX, START_RST_VAL);
        read_reg(REG_END_IDX, END_RST_VAL);
    endtask

    // One frame of extreme and single-bit values, with the registers
    // changed halfway through the frame.
    task automatic test_directed_frame();
        logic [CHAN_BITS-1:0] values[16] = '{
            11'h000, 11'h7FF, 11'h555, 11'h2AA, 11'h001, 11'h400, 11'h7FE, 11'h3FF,
            11'h7FF, 11'h000, 11'h0F0, 11'h70F, 11'h123, 11'h6DC, 11'h001, 11'h7FF
        };
        for (int i = 0; i < 8; i++)
            send_channel(values[i]);
        wait_drain();
        write_reg(REG_START_IDX, 8'h00);
        write_reg(REG_END_IDX, 8'hFF);
        for (int i = 8; i < 16; i++)
            send_channel(values[i]);
        wait_drain();
    endtask

    // Random channel streams in bursts, one register setting per phase.
    // Phase lengths are not a multiple of a frame, so the writes land mid-frame.
    task automatic test_random_phases();
        int sent;
        int burst;
        for (int phase = 0; phase < 4; phase++) begin
            wait_drain();
            case (phase)
                0: begin
                    write_reg(REG_START_IDX, 8'hFF);
                    write_reg(REG_END_IDX, 8'h00);
                end
                2: begin
                    write_reg(REG_START_IDX, START_RST_VAL);
                    write_reg(REG_END_IDX, 8'hFF);
                end
                default: begin
                    write_reg(REG_START_IDX, 8'($urandom_range(0, 255)));
                    write_reg(REG_END_IDX, 8'($urandom_range(0, 255)));
                end
            endcase
            sent = 0;
            while (sent < 50) begin
                burst = $urandom_range(1, 12);
                for (int i = 0; i < burst && sent < 50; i++) begin
                    send_channel(rand_channel());
                    sent++;
                end
                // Phase one runs without input gaps.
                if (phase != 1)
                    idle_input($urandom_range(0, 5));
            end
        end
        wait_drain();
    endtask

    // The output holds off for a long stretch while channels keep coming,
    // so the block fills and stalls its input; then the sender pauses.
    task automatic test_backpressure();
        hold_cycles = HOLD_CYCLES;
        for (int i = 0; i < 24; i++)
            send_channel(rand_channel());
        wait_drain();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_reset();
        test_directed_frame();
        test_random_phases();
        test_backpressure();

        wait_drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && frame_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
